FILE: rtl/bcq_pkg.sv
// Shared types, widths and constants for the battery cutoff qualifier.
// No dependencies; compiled first.
package bcq_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int UPPER_W   = 11;
    localparam int PERSIST_W = 16;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = 17;   // 1023 * 100 fits in 17 bits
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [PERSIST_W-1:0] PERSIST_RESET = 16'd300;
    localparam logic [PCT_W-1:0]     PCT_RESET     = 7'd2;
    localparam logic [PCT_W-1:0]     PCT_MAX       = 7'd100;

    // x / 100 = (x / 4) / 25; y / 25 = (y * ceil(2^19 / 25)) >> 19, exact for y < 43690
    localparam int                   DIV25_SHIFT = 19;
    localparam logic [14:0]          DIV25_RECIP = 15'd20972;

    typedef enum logic {
        REG_PERSIST = 1'b0,
        REG_PCT     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic relay_on;
        logic cut_event;
        logic restore_event;
    } t_persist_res;

    function automatic logic [SAMPLE_W-1:0] div100(input logic [PROD_W-1:0] x);
        logic [14:0] quarter;
        logic [29:0] prod;
        quarter = x[PROD_W-1:2];
        prod    = quarter * DIV25_RECIP;
        return prod[DIV25_SHIFT+SAMPLE_W-1:DIV25_SHIFT];
    endfunction

endpackage

FILE: rtl/bcq_if.sv
// Valid/ready channel interfaces for measurement items and result items.
// Depends on bcq_pkg for field widths.
interface bcq_in_if import bcq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] reference_sample;
    logic [SAMPLE_W-1:0] battery_sample;

    modport source (output valid, reference_sample, battery_sample, input ready);
    modport sink   (input valid, reference_sample, battery_sample, output ready);
endinterface

interface bcq_out_if import bcq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               relay_on;
    logic [UPPER_W-1:0] upper_threshold;
    logic               cut_event;
    logic               restore_event;

    modport source (output valid, relay_on, upper_threshold, cut_event, restore_event,
                    input ready);
    modport sink   (input valid, relay_on, upper_threshold, cut_event, restore_event,
                    output ready);
endinterface

FILE: rtl/bcq_persist.sv
// Persistence counters and relay state: low/high countdown, reload, switch.
// Depends on bcq_pkg.
module bcq_persist import bcq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_low_band,
    input  logic                 i_high_band,
    input  logic [PERSIST_W-1:0] i_persist_count,
    output t_persist_res         o_res
);

    logic [PERSIST_W-1:0] r_low_cnt, r_high_cnt;
    logic [PERSIST_W-1:0] n_low_cnt, n_high_cnt;
    logic                 r_relay, n_relay;
    logic                 low_expire, high_expire;

    always_comb begin
        low_expire  = 1'b0;
        high_expire = 1'b0;
        n_low_cnt   = i_persist_count;
        n_high_cnt  = i_persist_count;
        // a count of 0 or 1 expires on this step
        if (i_low_band) begin
            if (r_low_cnt <= PERSIST_W'(1)) begin
                low_expire = 1'b1;
            end else begin
                n_low_cnt = r_low_cnt - PERSIST_W'(1);
            end
        end
        if (i_high_band) begin
            if (r_high_cnt <= PERSIST_W'(1)) begin
                high_expire = 1'b1;
            end else begin
                n_high_cnt = r_high_cnt - PERSIST_W'(1);
            end
        end
        n_relay = r_relay;
        if (low_expire) begin
            n_relay = 1'b0;
        end
        if (high_expire) begin
            n_relay = 1'b1;
        end
    end

    always_comb begin
        o_res.relay_on      = n_relay;
        o_res.cut_event     = r_relay & ~n_relay;
        o_res.restore_event = ~r_relay & n_relay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt  <= PERSIST_RESET;
            r_high_cnt <= PERSIST_RESET;
            r_relay    <= 1'b1;
        end else if (i_step) begin
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
            r_relay    <= n_relay;
        end
    end

endmodule

FILE: rtl/battery_cutoff_hysteresis_qualifier_top.sv
// Battery cutoff qualifier: three-register pipeline (input, product, result).
// Each accepted item passes through the input, product and result registers in turn
// before its result is offered. Throughput: one item per cycle; each stage advances
// when it is empty or the next one advances.
// Reset (synchronous, active low): pipeline empty, persist_count 300, percent 2,
// both counters 300, relay on. Depends on bcq_pkg, bcq_if, bcq_persist.
module battery_cutoff_hysteresis_qualifier_top import bcq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcq_in_if.sink            i_meas,
    bcq_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [PERSIST_W-1:0] r_persist;
    logic [PCT_W-1:0]     r_pct;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persist <= PERSIST_RESET;
            r_pct     <= PCT_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_PERSIST: r_persist <= pwdata[PERSIST_W-1:0];
                REG_PCT:     r_pct     <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PERSIST: prdata = {{(APB_DW-PERSIST_W){1'b0}}, r_persist};
            REG_PCT:     prdata = {{(APB_DW-PCT_W){1'b0}}, r_pct};
            default:     prdata = '0;
        endcase
    end

    // pipeline control
    logic r_v1, r_v2, r_ov;
    logic s1_en, s2_en, out_en;

    assign out_en       = !r_ov || o_result.ready;
    assign s2_en        = !r_v2 || out_en;
    assign s1_en        = !r_v1 || s2_en;
    assign i_meas.ready = s1_en;

    // stage 1: captured measurement
    logic [SAMPLE_W-1:0] r_ref1, r_bat1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_en) begin
            r_v1 <= i_meas.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_ref1 <= i_meas.reference_sample;
            r_bat1 <= i_meas.battery_sample;
        end
    end

    // stage 2: reference times saturated percent
    logic [PCT_W-1:0]    pct_sat;
    logic [SAMPLE_W-1:0] r_ref2, r_bat2;
    logic [PROD_W-1:0]   r_prod2, n_prod2;

    assign pct_sat = (r_pct > PCT_MAX) ? PCT_MAX : r_pct;
    assign n_prod2 = PROD_W'(r_ref1) * PROD_W'(pct_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_ref2  <= r_ref1;
            r_bat2  <= r_bat1;
            r_prod2 <= n_prod2;
        end
    end

    // stage 3: threshold, band compare, counter update
    logic [UPPER_W-1:0] upper;
    logic               low_band, high_band, step;
    t_persist_res       pres;

    assign upper     = UPPER_W'(r_ref2) + UPPER_W'(div100(r_prod2));
    assign low_band  = (r_bat2 <= r_ref2);
    assign high_band = (UPPER_W'(r_bat2) > upper);
    assign step      = r_v2 && out_en;

    bcq_persist u_persist (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_low_band      (low_band),
        .i_high_band     (high_band),
        .i_persist_count (r_persist),
        .o_res           (pres)
    );

    // result register
    logic               r_relay_o, r_cut_o, r_restore_o;
    logic [UPPER_W-1:0] r_upper_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_en) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_relay_o   <= pres.relay_on;
            r_cut_o     <= pres.cut_event;
            r_restore_o <= pres.restore_event;
            r_upper_o   <= upper;
        end
    end

    assign o_result.valid           = r_ov;
    assign o_result.relay_on        = r_relay_o;
    assign o_result.upper_threshold = r_upper_o;
    assign o_result.cut_event       = r_cut_o;
    assign o_result.restore_event   = r_restore_o;

endmodule
